// File: hdl/bvse_pkg.sv
// Shared types, codes and word helpers for the bit vector set engine.
package bvse_pkg;

    localparam int MAX_BITS_DEF = 1024;
    localparam int LEN_W        = 11;
    localparam int LEN_MAX      = (2 ** LEN_W) - 1;

    localparam logic [31:0] POP_M3 = 32'h7777_7777;
    localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [3:0] {
        F_TEST    = 4'd0,
        F_SET     = 4'd1,
        F_CLEAR   = 4'd2,
        F_WRITE   = 4'd3,
        F_AND     = 4'd4,
        F_ANDNOT  = 4'd5,
        F_OR      = 4'd6,
        F_XOR     = 4'd7,
        F_COMPARE = 4'd8,
        F_ZERO    = 4'd9,
        F_ONES    = 4'd10,
        F_COUNT   = 4'd11,
        F_FIRST   = 4'd12,
        F_LAST    = 4'd13,
        F_HASH    = 4'd14
    } t_func;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WORD,
        S_FILL,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]  func;
        logic [9:0]  bit_index;
        logic [4:0]  word_index;
        logic [31:0] operand_word;
    } t_cmd;

    typedef struct packed {
        logic [31:0] result_value;
        logic        flag;
        logic        range_error;
    } t_rsp;

    // Population count of one word, nibble method then byte sum.
    function automatic logic [5:0] pop32(input logic [31:0] x);
        logic [31:0] v;
        logic [31:0] n;
        logic [7:0]  s;
        v = x;
        n = (v >> 1) & POP_M3;
        v = v - n;
        n = (n >> 1) & POP_M3;
        v = v - n;
        n = (n >> 1) & POP_M3;
        v = v - n;
        v = (v + (v >> 4)) & POP_M4;
        s = v[7:0] + v[15:8] + v[23:16] + v[31:24];
        return s[5:0];
    endfunction

    // Position of the lowest set bit.
    function automatic logic [4:0] ffs32(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // Position of the highest set bit.
    function automatic logic [4:0] fls32(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // Low n bits set; n is nonzero where used.
    function automatic logic [31:0] tail_mask(input logic [4:0] n);
        return (32'd1 << n) - 32'd1;
    endfunction

endpackage

// File: hdl/bvse_chan.sv
// Valid/ready channel carrying one payload of a given type.
interface bvse_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bit_vector_set_engine_unit.sv
// Top level of the bit vector set engine: word store, sequencer and response register.
//
//  port    | dir | payload                                        | request moves
//  --------+-----+------------------------------------------------+---------------------
//  i_cmd   | in  | func, bit_index, word_index, operand_word      | one command
//  o_rsp   | out | result_value, flag, range_error                 | one result
//  i_cfg   | in  | length_bits                                     | one register write
//
//  Test, set, clear and word commands do one memory read, then modify and write back; test and
//  compare write nothing back. Count, first, last and hash read the ceil(length/32) words in use,
//  one stored word per cycle through the single read port. Zero and ones write all MAX_BITS/32
//  stored words (rounded up), one write a cycle.
//  After reset a clearing pass writes zeros over all MAX_BITS/32 words (rounded up), i_cmd.ready
//  low meanwhile; i_cfg is taken at any time. A stalled result holds in the output register and
//  the sequencer waits in its last state until that register frees.
module bit_vector_set_engine_unit #(
    parameter int MAX_BITS = bvse_pkg::MAX_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bvse_chan.sink   i_cmd,
    bvse_chan.source o_rsp,
    bvse_chan.sink   i_cfg
);

    localparam int StoreWords = (MAX_BITS + 31) / 32;
    localparam int AW         = (StoreWords > 1) ? $clog2(StoreWords) : 1;
    localparam int CW         = AW + 1;
    localparam int LenCap     = (MAX_BITS > bvse_pkg::LEN_MAX) ? bvse_pkg::LEN_MAX : MAX_BITS;
    localparam int LW         = bvse_pkg::LEN_W;

    logic [31:0]       r_mem [StoreWords];
    logic [31:0]       r_rd_data;

    bvse_pkg::t_state  r_state, n_state;
    bvse_pkg::t_len    r_len;
    bvse_pkg::t_func   r_func, n_func;
    logic [4:0]        r_bpos, n_bpos;
    logic [31:0]       r_op, n_op;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_err, n_err;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pv, n_pv;
    logic [CW-1:0]     r_pidx, n_pidx;
    logic [31:0]       r_acc, n_acc;
    logic              r_flag, n_flag;
    logic              r_fill, n_fill;
    logic              r_rsp_valid;
    bvse_pkg::t_rsp    r_rsp, n_rsp;

    logic              rd_en, wr_en, load_rsp, slot_free;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [31:0]       wr_data;

    bvse_pkg::t_len    eff_len;
    logic [LW:0]       len_up;
    logic [CW-1:0]     nw;
    logic              tail_any;
    bvse_pkg::t_cmd    cmd;
    bvse_pkg::t_func   cmd_func;

    logic              word_tail;
    logic [31:0]       word_mask, bit_mask, word_new;
    logic              word_flag, word_we;

    logic              scan_tail;
    logic [31:0]       scan_mask, scan_dm, scan_base;

    assign eff_len  = (r_len > LW'(LenCap)) ? LW'(LenCap) : r_len;
    assign len_up   = {1'b0, eff_len} + (LW + 1)'(31);
    assign nw       = CW'(len_up[LW:5]);
    assign tail_any = (eff_len[4:0] != 5'd0);

    assign cmd      = i_cmd.data;
    assign cmd_func = bvse_pkg::t_func'(cmd.func);

    assign slot_free = !r_rsp_valid || o_rsp.ready;

    assign i_cmd.ready = (r_state == bvse_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // Single word read-modify-write datapath
    assign word_tail = tail_any && (32'(r_addr) == 32'(eff_len[LW-1:5]));
    assign word_mask = word_tail ? bvse_pkg::tail_mask(eff_len[4:0]) : '1;
    assign bit_mask  = 32'd1 << r_bpos;

    always_comb begin
        word_new  = r_rd_data;
        word_flag = 1'b0;
        word_we   = 1'b0;
        unique case (r_func) inside
            bvse_pkg::F_TEST: begin
                word_flag = r_rd_data[r_bpos];
            end
            bvse_pkg::F_SET: begin
                word_new = r_rd_data | bit_mask;
                word_we  = 1'b1;
            end
            bvse_pkg::F_CLEAR: begin
                word_new = r_rd_data & ~bit_mask;
                word_we  = 1'b1;
            end
            bvse_pkg::F_WRITE: begin
                word_new = r_op;
                word_we  = 1'b1;
            end
            bvse_pkg::F_AND: begin
                word_new = r_rd_data & r_op;
                word_we  = 1'b1;
            end
            bvse_pkg::F_ANDNOT: begin
                word_new = r_rd_data & ~r_op;
                word_we  = 1'b1;
            end
            bvse_pkg::F_OR: begin
                word_new = r_rd_data | r_op;
                word_we  = 1'b1;
            end
            bvse_pkg::F_XOR: begin
                word_new = r_rd_data ^ r_op;
                word_we  = 1'b1;
            end
            bvse_pkg::F_COMPARE: begin
                word_flag = (((r_rd_data ^ r_op) & word_mask) == 32'd0);
            end
            default: begin
                word_new = r_rd_data;
            end
        endcase
    end

    // Scan datapath: word r_pidx arrives in r_rd_data
    assign scan_tail = tail_any && (32'(r_pidx) == 32'(eff_len[LW-1:5]));
    assign scan_mask = scan_tail ? bvse_pkg::tail_mask(eff_len[4:0]) : '1;
    assign scan_dm   = r_rd_data & scan_mask;
    assign scan_base = 32'(r_pidx) << 5;

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_bpos   = r_bpos;
        n_op     = r_op;
        n_addr   = r_addr;
        n_err    = r_err;
        n_idx    = r_idx;
        n_pv     = 1'b0;
        n_pidx   = r_pidx;
        n_acc    = r_acc;
        n_flag   = r_flag;
        n_fill   = r_fill;
        n_rsp    = '0;
        load_rsp = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_addr;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = word_new;

        unique case (r_state) inside
            bvse_pkg::S_CLEAR, bvse_pkg::S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = {32{r_fill}};
                n_idx   = r_idx + CW'(1);
                if (r_idx[AW-1:0] == AW'(StoreWords - 1)) begin
                    n_state = (r_state == bvse_pkg::S_CLEAR) ? bvse_pkg::S_IDLE
                                                             : bvse_pkg::S_DONE;
                end
            end

            bvse_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_func = cmd_func;
                    n_bpos = cmd.bit_index[4:0];
                    n_op   = cmd.operand_word;
                    n_idx  = '0;
                    n_err  = 1'b0;
                    n_flag = 1'b0;
                    n_acc  = '0;
                    n_fill = 1'b0;
                    unique case (cmd_func) inside
                        [bvse_pkg::F_TEST:bvse_pkg::F_CLEAR]: begin
                            n_err   = ({1'b0, cmd.bit_index} >= eff_len);
                            n_addr  = AW'(cmd.bit_index[9:5]);
                            rd_en   = 1'b1;
                            rd_addr = n_addr;
                            n_state = bvse_pkg::S_WORD;
                        end
                        [bvse_pkg::F_WRITE:bvse_pkg::F_COMPARE]: begin
                            n_err   = (32'(cmd.word_index) >= 32'(nw));
                            n_addr  = AW'(cmd.word_index);
                            rd_en   = 1'b1;
                            rd_addr = n_addr;
                            n_state = bvse_pkg::S_WORD;
                        end
                        bvse_pkg::F_ZERO, bvse_pkg::F_ONES: begin
                            n_fill  = (cmd_func == bvse_pkg::F_ONES);
                            n_state = bvse_pkg::S_FILL;
                        end
                        bvse_pkg::F_FIRST, bvse_pkg::F_LAST: begin
                            n_acc   = '1;
                            n_state = bvse_pkg::S_SCAN;
                        end
                        bvse_pkg::F_COUNT, bvse_pkg::F_HASH: begin
                            n_state = bvse_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = bvse_pkg::S_DONE;
                        end
                    endcase
                end
            end

            bvse_pkg::S_WORD: begin
                // keep the read on the same word so its data holds across a stall
                rd_en   = 1'b1;
                rd_addr = r_addr;
                if (slot_free) begin
                    wr_en              = word_we && !r_err;
                    wr_addr            = r_addr;
                    wr_data            = word_new;
                    load_rsp           = 1'b1;
                    n_rsp.result_value = '0;
                    n_rsp.flag         = word_flag && !r_err;
                    n_rsp.range_error  = r_err;
                    n_state            = bvse_pkg::S_IDLE;
                end
            end

            bvse_pkg::S_SCAN: begin
                if (r_idx != nw) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_idx   = r_idx + CW'(1);
                    n_pv    = 1'b1;
                    n_pidx  = r_idx;
                end else if (!r_pv) begin
                    n_state = bvse_pkg::S_DONE;
                end
                if (r_pv) begin
                    case (r_func)
                        bvse_pkg::F_COUNT: begin
                            n_acc = r_acc + 32'(bvse_pkg::pop32(scan_dm));
                        end
                        bvse_pkg::F_FIRST: begin
                            if (!r_flag && scan_dm != 32'd0) begin
                                n_acc  = scan_base | 32'(bvse_pkg::ffs32(scan_dm));
                                n_flag = 1'b1;
                            end
                        end
                        bvse_pkg::F_LAST: begin
                            if (scan_dm != 32'd0) begin
                                n_acc  = scan_base | 32'(bvse_pkg::fls32(scan_dm));
                                n_flag = 1'b1;
                            end
                        end
                        bvse_pkg::F_HASH: begin
                            if (scan_tail) begin
                                n_acc = r_acc ^ scan_dm ^ 32'(eff_len);
                            end else begin
                                n_acc = (r_acc ^ r_rd_data) << 1;
                            end
                        end
                        default: begin
                            n_acc = r_acc;
                        end
                    endcase
                end
            end

            bvse_pkg::S_DONE: begin
                if (slot_free) begin
                    load_rsp           = 1'b1;
                    n_rsp.result_value = r_acc;
                    n_rsp.flag         = r_flag;
                    n_rsp.range_error  = r_err;
                    n_state            = bvse_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bvse_pkg::S_IDLE;
            end
        endcase
    end

    // Word store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvse_pkg::S_CLEAR;
            r_len       <= LW'(LenCap);
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_fill      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_fill  <= n_fill;
            if (i_cfg.valid) begin
                r_len <= i_cfg.data;
            end
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload and accumulators
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_bpos <= n_bpos;
        r_op   <= n_op;
        r_addr <= n_addr;
        r_err  <= n_err;
        r_pidx <= n_pidx;
        r_acc  <= n_acc;
        r_flag <= n_flag;
        if (load_rsp) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
